>>> rtl/bitmap_frame_allocator_core_defines.svh
// Assertion macros shared by the frame allocator RTL.
// Included by the controller and the datapath; depends on nothing else.
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BFA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
// Used by bfa_ctrl, bfa_datapath and bitmap_frame_allocator_core; no dependencies.
package bfa_pkg;

   localparam int FRAME_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int WORD_W   = 64;
   localparam int BIT_W    = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RESERVE = 2'd2,
      OP_QUERY   = 2'd3
   } bfa_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOMEM = 2'd1,
      ST_RANGE = 2'd2
   } bfa_status_type;

   typedef enum logic [1:0] {
      S_CLEAR = 2'd0,
      S_IDLE  = 2'd1,
      S_EXEC  = 2'd2
   } bfa_state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic advance;
      logic commit;
   } bfa_cmd_type;

   typedef struct packed {
      logic last_word;
      logic finish;
      logic out_free;
   } bfa_stat_type;

endpackage

>>> rtl/bfa_ctrl.sv
// Sequencer of the frame allocator: bitmap clear after reset, accept, word scan, result.
// Depends on bfa_pkg and bitmap_frame_allocator_core_defines.svh.
`include "bitmap_frame_allocator_core_defines.svh"

module bfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bfa_pkg::bfa_stat_type stat,
   output bfa_pkg::bfa_cmd_type  cmd
);

   bfa_pkg::bfa_state_type state_ff;
   bfa_pkg::bfa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         bfa_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.last_word) begin
               state_in = bfa_pkg::S_IDLE;
            end
         end
         bfa_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = bfa_pkg::S_EXEC;
            end
         end
         bfa_pkg::S_EXEC: begin
            // A decided item waits here until the result register can take it.
            if (!stat.finish) begin
               cmd.advance = 1'b1;
            end else if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = bfa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfa_pkg::S_IDLE;
         end
      endcase
   end

   `BFA_ASSERT_IMP(a_commit_needs_slot, clock, reset, cmd.commit, stat.out_free, "commit while result register busy")
   `BFA_ASSERT_NXT(a_load_starts_exec, clock, reset, cmd.load, state_ff == bfa_pkg::S_EXEC, "accepted item did not start")

endmodule

>>> rtl/bfa_datapath.sv
// Datapath of the frame allocator: bitmap memory, word scan, count, limit and result register.
// Depends on bfa_pkg and bitmap_frame_allocator_core_defines.svh.
`include "bitmap_frame_allocator_core_defines.svh"

module bfa_datapath #(
   parameter int MAX_FRAMES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_tuser,
   input  logic [bfa_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bfa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_valid,
   input  logic [bfa_pkg::COUNT_W-1:0]       csr_data,
   input  bfa_pkg::bfa_cmd_type              cmd,
   output bfa_pkg::bfa_stat_type             stat
);

   localparam int MAP_WORDS = (MAX_FRAMES + 63) / 64;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW        = AW + bfa_pkg::BIT_W;
   localparam int CW        = (BW > bfa_pkg::COUNT_W) ? BW + 1 : bfa_pkg::COUNT_W + 1;
   localparam int LIMIT_RST = (MAX_FRAMES < 1024) ? MAX_FRAMES : 1024;
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

   logic [bfa_pkg::WORD_W-1:0] mem [MAP_WORDS];
   logic [bfa_pkg::WORD_W-1:0] rdata_ff;
   logic [bfa_pkg::WORD_W-1:0] wdata;
   logic                       mem_we;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              cur_word_ff;
   logic [AW-1:0]              cur_word_in;

   bfa_pkg::bfa_op_type        op_ff;
   logic [bfa_pkg::FRAME_W-1:0] fn_ff;
   logic [bfa_pkg::COUNT_W-1:0] limit_ff;
   logic [bfa_pkg::COUNT_W-1:0] limit_in;
   logic [bfa_pkg::COUNT_W-1:0] used_ff;
   logic [bfa_pkg::COUNT_W-1:0] used_in;

   logic                        rsp_valid_ff;
   logic [bfa_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0]                  rsp_user_ff;

   logic [CW-1:0]               base_ext;
   logic [CW-1:0]               lim_ext;
   logic [CW-1:0]               span;
   logic                        word_live;
   logic                        span_full;
   logic [bfa_pkg::WORD_W-1:0]  mask;
   logic [bfa_pkg::WORD_W-1:0]  masked;
   logic                        any_free;
   logic [bfa_pkg::BIT_W-1:0]   first_idx;
   logic                        in_range;
   logic                        fn_bit;
   logic                        alloc_ok;
   logic [bfa_pkg::WORD_W-1:0]  new_word;
   logic                        word_dirty;
   logic [bfa_pkg::FRAME_W-1:0] res_frame;
   bfa_pkg::bfa_status_type     res_status;
   logic                        res_free;

   // Active limit is min(frame_count, MAX_FRAMES), kept already clamped.
   always_comb begin
      if (32'(csr_data) > MAX_FRAMES) begin
         limit_in = bfa_pkg::COUNT_W'(MAX_FRAMES);
      end else begin
         limit_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bfa_pkg::COUNT_W'(LIMIT_RST);
      end else if (csr_valid) begin
         limit_ff <= limit_in;
      end
   end

   // Scan window of the current word, clipped by the active limit.
   always_comb begin
      base_ext  = CW'({cur_word_ff, {bfa_pkg::BIT_W{1'b0}}});
      lim_ext   = CW'(limit_ff);
      word_live = base_ext < lim_ext;
      span      = lim_ext - base_ext;
      span_full = span >= CW'(bfa_pkg::WORD_W);
      for (int i = 0; i < bfa_pkg::WORD_W; i++) begin
         mask[i] = span_full || (span[bfa_pkg::BIT_W-1:0] > bfa_pkg::BIT_W'(i));
      end
      masked   = rdata_ff & mask;
      any_free = |masked;
      first_idx = '0;
      for (int i = bfa_pkg::WORD_W - 1; i >= 0; i--) begin
         if (masked[i]) begin
            first_idx = bfa_pkg::BIT_W'(i);
         end
      end
   end

   always_comb begin
      in_range   = bfa_pkg::COUNT_W'(fn_ff) < limit_ff;
      fn_bit     = rdata_ff[fn_ff[bfa_pkg::BIT_W-1:0]];
      alloc_ok   = word_live && any_free;
      new_word   = rdata_ff;
      word_dirty = 1'b0;
      res_frame  = fn_ff;
      res_status = bfa_pkg::ST_OK;
      res_free   = 1'b0;
      used_in    = used_ff;
      case (op_ff)
         bfa_pkg::OP_ALLOC: begin
            if (alloc_ok) begin
               new_word   = rdata_ff & ~(bfa_pkg::WORD_W'(1) << first_idx);
               word_dirty = 1'b1;
               res_frame  = bfa_pkg::FRAME_W'({cur_word_ff, first_idx});
               if (used_ff != bfa_pkg::COUNT_MAX) begin
                  used_in = used_ff + 1'b1;
               end
            end else begin
               res_frame  = '0;
               res_status = bfa_pkg::ST_NOMEM;
            end
         end
         bfa_pkg::OP_FREE: begin
            if (!in_range) begin
               res_status = bfa_pkg::ST_RANGE;
            end else begin
               new_word   = rdata_ff | (bfa_pkg::WORD_W'(1) << fn_ff[bfa_pkg::BIT_W-1:0]);
               word_dirty = 1'b1;
               if (used_ff != '0) begin
                  used_in = used_ff - 1'b1;
               end
            end
         end
         bfa_pkg::OP_RESERVE: begin
            if (!in_range) begin
               res_status = bfa_pkg::ST_RANGE;
            end else begin
               new_word   = rdata_ff & ~(bfa_pkg::WORD_W'(1) << fn_ff[bfa_pkg::BIT_W-1:0]);
               word_dirty = 1'b1;
            end
         end
         bfa_pkg::OP_QUERY: begin
            if (!in_range) begin
               res_status = bfa_pkg::ST_RANGE;
            end else begin
               res_free = fn_bit;
            end
         end
         default: begin
            res_status = bfa_pkg::ST_RANGE;
         end
      endcase
   end

   // An allocate goes on to the next word only while nothing is found and words remain.
   always_comb begin
      stat.last_word = cur_word_ff == LAST_WORD;
      stat.finish    = (op_ff != bfa_pkg::OP_ALLOC) || !word_live || any_free
                       || (cur_word_ff == LAST_WORD);
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      cur_word_in = cur_word_ff;
      rd_addr     = cur_word_ff;
      if (cmd.clear) begin
         cur_word_in = (cur_word_ff == LAST_WORD) ? '0 : cur_word_ff + 1'b1;
      end else if (cmd.load) begin
         if (bfa_pkg::bfa_op_type'(req_tuser) == bfa_pkg::OP_ALLOC) begin
            rd_addr = '0;
         end else begin
            rd_addr = AW'(req_tdata[bfa_pkg::FRAME_W-1:0] >> bfa_pkg::BIT_W);
         end
         cur_word_in = rd_addr;
      end else if (cmd.advance) begin
         rd_addr     = cur_word_ff + 1'b1;
         cur_word_in = rd_addr;
      end
      mem_we = cmd.clear || (cmd.commit && word_dirty);
      wdata  = cmd.clear ? '1 : new_word;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_word_ff] <= wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_word_ff <= '0;
         used_ff     <= '0;
      end else begin
         cur_word_ff <= cur_word_in;
         if (cmd.commit) begin
            used_ff <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= bfa_pkg::bfa_op_type'(req_tuser);
         fn_ff <= req_tdata[bfa_pkg::FRAME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= bfa_pkg::RSP_DATA_W'({used_in, res_free, res_frame});
         rsp_user_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `BFA_ASSERT_NXT(a_count_holds, clock, reset, !cmd.commit, $stable(used_ff), "used count moved without a commit")
   `BFA_ASSERT_NXT(a_alloc_counts, clock, reset, cmd.commit && op_ff == bfa_pkg::OP_ALLOC && alloc_ok && used_ff != bfa_pkg::COUNT_MAX, used_ff == bfa_pkg::COUNT_W'($past(used_ff) + 1'b1), "grant not counted")

endmodule

>>> rtl/bitmap_frame_allocator_core.sv
// First-fit physical frame allocator over a free bitmap held in a 64-bit-wide memory
// of ceil(MAX_FRAMES/64) words. After reset a clearing pass over every word marks every
// frame free; no item is taken during it, configuration writes are.
// One item is worked at a time. Free, reserve and query read one bitmap word, rewrite it
// for an in-range free or reserve, and pass their result from the registered word read
// into the output register once that register can take it. Allocate reads one bitmap word
// per cycle from word 0 until it finds a free frame below the active limit or runs out
// of live words, then waits in the same way for the output register.
// The next item is accepted in the cycle after the result enters the output register,
// even while that result is still waiting.
// Depends on bfa_pkg, bfa_ctrl and bfa_datapath.

module bitmap_frame_allocator_core #(
   parameter int MAX_FRAMES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] frame_number, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] frame, [10] frame_is_free, [21:11] used_count
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data     // frame_count
);

   bfa_pkg::bfa_cmd_type  cmd;
   bfa_pkg::bfa_stat_type stat;

   // The limit register takes a write in any cycle.
   assign csr_ready = 1'b1;

   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bfa_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

>>> verif/frame_alloc_checker.sv
`timescale 1ns / 1ps
// Checker for the bitmap frame allocator: shadows the free bitmap and the used count,
// predicts the response to each accepted request and compares it with the DUT output.
// Depends on bfa_pkg; instantiated by tb next to bitmap_frame_allocator_core.

module frame_alloc_checker #(
   parameter int MAX_FRAMES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] frame_number, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [9:0] frame, [10] frame_is_free, [21:11] used_count
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [10:0] csr_data,    // frame_count
   output int          outstanding,
   output int          mismatches,
   output int          responses_checked
);

   typedef struct packed {
      logic [bfa_pkg::FRAME_W-1:0] frame;
      logic [1:0]                  status;
      logic                        is_free;
      logic [bfa_pkg::COUNT_W-1:0] used;
   } frame_response_type;

   logic [MAX_FRAMES-1:0]       shadow_free;
   logic [bfa_pkg::COUNT_W-1:0] shadow_used;
   logic [bfa_pkg::COUNT_W-1:0] shadow_frame_count;
   frame_response_type          expected_responses[$];

   initial begin
      outstanding = 0;
      mismatches = 0;
      responses_checked = 0;
   end

   // Applies one request to the shadow state and returns the response it should give.
   function automatic frame_response_type compute_response(bfa_pkg::bfa_op_type op,
                                                           logic [bfa_pkg::FRAME_W-1:0] fn);
      frame_response_type r;
      int limit;
      bit found;
      limit = (shadow_frame_count > MAX_FRAMES) ? MAX_FRAMES : int'(shadow_frame_count);
      r.frame = fn;
      r.status = bfa_pkg::ST_OK;
      r.is_free = 1'b0;
      if (op == bfa_pkg::OP_ALLOC) begin
         found = 1'b0;
         for (int f = 0; f < limit && !found; f++) begin
            if (shadow_free[f]) begin
               found = 1'b1;
               r.frame = bfa_pkg::FRAME_W'(f);
               shadow_free[f] = 1'b0;
            end
         end
         if (found) begin
            if (shadow_used != bfa_pkg::COUNT_MAX) shadow_used++;
         end else begin
            r.frame = '0;
            r.status = bfa_pkg::ST_NOMEM;
         end
      end else if (int'(fn) >= limit) begin
         r.status = bfa_pkg::ST_RANGE;
      end else if (op == bfa_pkg::OP_FREE) begin
         shadow_free[fn] = 1'b1;
         if (shadow_used != '0) shadow_used--;
      end else if (op == bfa_pkg::OP_RESERVE) begin
         shadow_free[fn] = 1'b0;
      end else begin
         r.is_free = shadow_free[fn];
      end
      r.used = shadow_used;
      return r;
   endfunction

   // All reads here see the values from before the edge, since the DUT updates
   // its registers with nonblocking assignments.
   always @(posedge clock) begin
      frame_response_type got;
      frame_response_type want;
      if (reset) begin
         shadow_free = '1;
         shadow_used = '0;
         shadow_frame_count = 11'd1024;
         expected_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.frame = rsp_tdata[9:0];
            got.is_free = rsp_tdata[10];
            got.used = rsp_tdata[21:11];
            got.status = rsp_tuser;
            responses_checked++;
            if (expected_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t checker: response with none pending: frame %0d status %0d",
                           $realtime, got.frame, got.status);
            end else begin
               want = expected_responses.pop_front();
               if (got.frame !== want.frame || got.status !== want.status ||
                   got.is_free !== want.is_free || got.used !== want.used) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t checker: mismatch frame %0d/%0d status %0d/%0d ",
                               "free %0d/%0d used %0d/%0d (expected/actual)"},
                              $realtime, want.frame, got.frame, want.status, got.status,
                              want.is_free, got.is_free, want.used, got.used);
               end
            end
         end
         if (csr_valid && csr_ready) shadow_frame_count = csr_data;
         if (req_tvalid && req_tready)
            expected_responses.push_back(
               compute_response(bfa_pkg::bfa_op_type'(req_tuser), req_tdata[9:0]));
      end
      outstanding = expected_responses.size();
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Top of the frame allocator testbench: clock, reset, request and frame-count stimulus,
// response back-pressure and the verdict. Depends on bfa_pkg, frame_alloc_checker and
// bitmap_frame_allocator_core.

module tb;

   localparam int MAX_FRAMES    = 1024;
   localparam int QUIET_LIMIT   = 5000;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_PERCENT  = 14;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_data;

   int outstanding;
   int mismatches;
   int responses_checked;

   logic req_fire;
   logic rsp_fire;
   logic csr_fire;
   bit   calm;
   bit   stall_request;
   int   active_frames;
   int   requests_sent;
   int   settings_written;

   bitmap_frame_allocator_core #(.MAX_FRAMES(MAX_FRAMES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   frame_alloc_checker #(.MAX_FRAMES(MAX_FRAMES)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .outstanding       (outstanding),
      .mismatches        (mismatches),
      .responses_checked (responses_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Handshake flags, captured at the rising edge and read by the drivers at the falling one.
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      rsp_fire <= rsp_tvalid && rsp_tready;
      csr_fire <= csr_valid && csr_ready;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            stall_request = 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(negedge clock);
         if (req_fire || rsp_fire || csr_fire) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic send_request(bfa_pkg::bfa_op_type op, logic [bfa_pkg::FRAME_W-1:0] fn);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, fn};
      do @(negedge clock); while (!req_fire);
      requests_sent++;
   endtask

   // Stops offering requests and waits until every response has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic set_frame_count(logic [bfa_pkg::COUNT_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
      active_frames = (value > MAX_FRAMES) ? MAX_FRAMES : int'(value);
      settings_written++;
   endtask

   // Mostly frames below the active limit, with a bias toward the low ones that
   // allocate hands out first; now and then any frame number at all.
   function automatic logic [bfa_pkg::FRAME_W-1:0] pick_frame();
      int roll;
      roll = $urandom_range(0, 99);
      if (active_frames > 0 && roll < 45)
         return bfa_pkg::FRAME_W'(
            $urandom_range(0, (active_frames > 64 ? 64 : active_frames) - 1));
      if (active_frames > 0 && roll < 85)
         return bfa_pkg::FRAME_W'($urandom_range(0, active_frames - 1));
      return bfa_pkg::FRAME_W'($urandom_range(0, 1023));
   endfunction

   function automatic bfa_pkg::bfa_op_type pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return bfa_pkg::OP_ALLOC;
      if (roll < 65) return bfa_pkg::OP_FREE;
      if (roll < 75) return bfa_pkg::OP_RESERVE;
      return bfa_pkg::OP_QUERY;
   endfunction

   initial begin : stimulus
      int plan[10] = '{1024, 64, 1, 65, 2047, 1000, 0, 128, 0, 0};
      int batch;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = bfa_pkg::OP_ALLOC;
      csr_valid = 1'b0;
      csr_data = '0;
      calm = 1'b0;
      stall_request = 1'b0;
      active_frames = MAX_FRAMES;
      requests_sent = 0;
      settings_written = 0;
      plan[7] = $urandom_range(1, 1024);
      plan[9] = $urandom_range(1, 1024);
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset frame count of 1024.
      send_request(bfa_pkg::OP_ALLOC, 10'h3FF);
      send_request(bfa_pkg::OP_ALLOC, 10'h000);
      send_request(bfa_pkg::OP_QUERY, 10'd0);
      send_request(bfa_pkg::OP_QUERY, 10'd1023);
      send_request(bfa_pkg::OP_FREE, 10'd0);
      send_request(bfa_pkg::OP_QUERY, 10'd0);
      send_request(bfa_pkg::OP_FREE, 10'd0);          // already free: count still drops
      send_request(bfa_pkg::OP_FREE, 10'd512);        // count stays at zero
      send_request(bfa_pkg::OP_RESERVE, 10'd1);       // already used
      send_request(bfa_pkg::OP_RESERVE, 10'd2);
      send_request(bfa_pkg::OP_ALLOC, 10'h155);
      send_request(bfa_pkg::OP_ALLOC, 10'h2AA);       // must skip the reserved frame
      send_request(bfa_pkg::OP_RESERVE, 10'd1023);
      send_request(bfa_pkg::OP_QUERY, 10'd1023);
      // No frame in range at all.
      set_frame_count(11'd0);
      send_request(bfa_pkg::OP_ALLOC, 10'd0);
      send_request(bfa_pkg::OP_FREE, 10'd0);
      send_request(bfa_pkg::OP_RESERVE, 10'd5);
      send_request(bfa_pkg::OP_QUERY, 10'd0);
      // Frame count beyond the bitmap is clamped.
      set_frame_count(11'd2047);
      send_request(bfa_pkg::OP_QUERY, 10'd1023);
      send_request(bfa_pkg::OP_FREE, 10'd1023);
      // Tiny limit: out of memory and out of range.
      set_frame_count(11'd2);
      send_request(bfa_pkg::OP_ALLOC, 10'd7);
      send_request(bfa_pkg::OP_QUERY, 10'd2);
      send_request(bfa_pkg::OP_FREE, 10'd1);
      send_request(bfa_pkg::OP_ALLOC, 10'd0);
      set_frame_count(11'd65);
      send_request(bfa_pkg::OP_RESERVE, 10'd64);
      send_request(bfa_pkg::OP_ALLOC, 10'd0);

      for (int p = 0; p < 10; p++) begin
         set_frame_count(bfa_pkg::COUNT_W'(plan[p]));
         calm = (p == 5);
         batch = (plan[p] == 0) ? 40 : 190;
         for (int i = 0; i < batch; i++) begin
            // Hold the response side off for a long while; requests keep coming.
            if (p == 3 && i == 20) stall_request = 1'b1;
            send_request(pick_op(), pick_frame());
         end
      end
      calm = 1'b0;

      drain();
      repeat (40) @(negedge clock);
      $display("tb: %0d requests over %0d frame-count settings, %0d responses checked",
               requests_sent, settings_written + 1, responses_checked);
      $display("tb: %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_ctrl.sv
rtl/bfa_datapath.sv
rtl/bitmap_frame_allocator_core.sv
verif/frame_alloc_checker.sv
verif/tb.sv
